### rtl/lav_pkg.sv
// ---------------------------------------------------------------------------
// lav_pkg
// Shared types and constants for the look-at view matrix block.
// ---------------------------------------------------------------------------
package lav_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STEPS    = 32;
  localparam int IN_DATA_W     = 9 * WORD_W;
  localparam int OUT_DATA_W    = 4 * WORD_W;
  localparam int OUT_USER_W    = 3;

  // op codes of the input item
  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_TARGET  = 1'b1;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic           op;
    word_t [2:0]    cam;
    word_t [2:0]    aim;
    word_t [2:0]    up;
  } item_t;

  typedef struct packed {
    word_t [2:0] r;
    word_t [2:0] u;
    word_t [2:0] f;
    word_t [2:0] t;
    logic        deg;
  } matrix_t;

  typedef struct packed {
    logic        done;
    logic        zero;
    word_t [2:0] v;
  } norm_res_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DLOAD,
    N_DIV
  } norm_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_FSTART,
    B_FWAIT,
    B_NEGF,
    B_CROSS,
    B_RSTART,
    B_RWAIT,
    B_DOT,
    B_TRANS,
    B_HAND
  } back_state_t;

endpackage

### rtl/lav_front.sv
// ---------------------------------------------------------------------------
// lav_front
// Input side: accepts items into a two-entry queue and unpacks the fields.
// ---------------------------------------------------------------------------
module lav_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lav_pkg::IN_DATA_W-1:0] s_tdata,  // camera x/y/z, aim x/y/z, up x/y/z
  input  logic                          s_tuser,  // op
  output lav_pkg::item_t                item,
  output logic                          item_valid,
  input  logic                          item_ready
);

  lav_pkg::item_t mem [2];
  lav_pkg::item_t in_item;
  logic           wp;
  logic           rp;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  // unpack the beat
  always_comb begin
    in_item.op = s_tuser;
    for (int i = 0; i < 3; i++) begin
      in_item.cam[i] = s_tdata[i*lav_pkg::WORD_W +: lav_pkg::WORD_W];
      in_item.aim[i] = s_tdata[(3+i)*lav_pkg::WORD_W +: lav_pkg::WORD_W];
      in_item.up[i]  = s_tdata[(6+i)*lav_pkg::WORD_W +: lav_pkg::WORD_W];
    end
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != 2'd0);
  assign pop        = item_valid && item_ready;
  assign item       = mem[rp];

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_item;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/lav_norm.sv
// ---------------------------------------------------------------------------
// lav_norm
// Iterative normalize unit: scale, sum of squares, square root, divide.
// ---------------------------------------------------------------------------
module lav_norm #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2:0]            neg,
  input  logic [2:0][63:0]      mag,
  output lav_pkg::norm_res_t    res
);

  localparam int QW   = FRAC_BITS + 1;
  localparam int NUMW = FRAC_BITS + 33;
  localparam int DW   = 33;
  localparam int RW   = 34;
  localparam int QCW  = $clog2(QW);

  lav_pkg::norm_state_t state, state_next;

  logic [2:0]            sgn;
  logic [2:0][63:0]      mg;
  logic [63:0]           m;
  logic [63:0]           sum;
  logic [63:0]           sx;
  logic [63:0]           sres;
  logic [63:0]           sbit;
  logic [4:0]            step;
  logic [1:0]            comp;
  logic [QCW-1:0]        qcnt;
  logic [QW-1:0]         nlow;
  logic [RW-1:0]         rem;
  logic [QW-1:0]         quo;
  logic [DW-1:0]         dvs;

  logic [63:0]           mx;
  logic [63:0]           sq;
  logic [63:0]           tv;
  logic [NUMW-1:0]       numv;
  logic [RW-1:0]         trial;
  logic                  qbit;
  logic [QW-1:0]         qfin;
  lav_pkg::word_t        qword;

  // largest magnitude of the incoming vector
  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
  end

  assign sq    = {32'd0, mg[comp][31:0]} * {32'd0, mg[comp][31:0]};
  assign tv    = sres + sbit;
  assign numv  = (NUMW'(mg[comp][30:0]) << QW) + NUMW'(sres[31:0]);
  assign trial = {rem[RW-2:0], nlow[QW-1]};
  assign qbit  = (trial >= RW'(dvs));
  assign qfin  = {quo[QW-2:0], qbit};
  assign qword = sgn[comp] ? -lav_pkg::word_t'(qfin) : lav_pkg::word_t'(qfin);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lav_pkg::N_IDLE:  if (start && mx != 64'd0) state_next = lav_pkg::N_SHIFT;
      lav_pkg::N_SHIFT: if (m[63:31] == 33'd0 && m[30]) state_next = lav_pkg::N_SQ;
      lav_pkg::N_SQ:    if (comp == 2'd2) state_next = lav_pkg::N_SQRT;
      lav_pkg::N_SQRT:  if (step == 5'(lav_pkg::SQRT_STEPS - 1)) state_next = lav_pkg::N_DLOAD;
      lav_pkg::N_DLOAD: state_next = lav_pkg::N_DIV;
      lav_pkg::N_DIV: begin
        if (qcnt == QCW'(QW - 1)) begin
          state_next = (comp == 2'd2) ? lav_pkg::N_IDLE : lav_pkg::N_DLOAD;
        end
      end
      default: state_next = lav_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lav_pkg::N_IDLE;
      res.done <= 1'b0;
    end else begin
      state    <= state_next;
      res.done <= (state == lav_pkg::N_IDLE && start && mx == 64'd0) ||
                  (state == lav_pkg::N_DIV && qcnt == QCW'(QW - 1) && comp == 2'd2);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      lav_pkg::N_IDLE: begin
        if (start) begin
          mg       <= mag;
          sgn      <= neg;
          m        <= mx;
          res.zero <= (mx == 64'd0);
          if (mx == 64'd0) res.v <= '0;
        end
      end
      lav_pkg::N_SHIFT: begin
        // scale so the largest magnitude lands in [2^30, 2^31)
        priority if (m[63:39] != 25'd0) begin
          m <= m >> 8;
          for (int i = 0; i < 3; i++) mg[i] <= mg[i] >> 8;
        end else if (m[63:31] != 33'd0) begin
          m <= m >> 1;
          for (int i = 0; i < 3; i++) mg[i] <= mg[i] >> 1;
        end else if (m[30:22] == 9'd0) begin
          m <= m << 8;
          for (int i = 0; i < 3; i++) mg[i] <= mg[i] << 8;
        end else if (!m[30]) begin
          m <= m << 1;
          for (int i = 0; i < 3; i++) mg[i] <= mg[i] << 1;
        end else begin
          sum  <= '0;
          comp <= 2'd0;
        end
      end
      lav_pkg::N_SQ: begin
        sum  <= sum + sq;
        comp <= comp + 2'd1;
        if (comp == 2'd2) begin
          sx   <= sum + sq;
          sres <= '0;
          sbit <= 64'd1 << 62;
          step <= 5'd0;
        end
      end
      lav_pkg::N_SQRT: begin
        // one result bit per step
        if (sx >= tv) begin
          sx   <= sx - tv;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
        step <= step + 5'd1;
        comp <= 2'd0;
      end
      lav_pkg::N_DLOAD: begin
        dvs  <= {sres[31:0], 1'b0};
        rem  <= RW'(numv[NUMW-1:QW]);
        nlow <= numv[QW-1:0];
        qcnt <= '0;
        quo  <= '0;
      end
      lav_pkg::N_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem  <= qbit ? (trial - RW'(dvs)) : trial;
        quo  <= qfin;
        nlow <= nlow << 1;
        qcnt <= qcnt + QCW'(1);
        if (qcnt == QCW'(QW - 1)) begin
          res.v[comp] <= qword;
          comp        <= comp + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/lav_back.sv
// ---------------------------------------------------------------------------
// lav_back
// Compute sequencer: forward vector, cross product, right vector and
// translation terms, sharing one 32x32 multiplier and the normalize unit.
// ---------------------------------------------------------------------------
module lav_back #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  lav_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_ready,
  output lav_pkg::matrix_t mat,
  output logic             mat_valid,
  input  logic             mat_ready
);

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [66:0] WMAX = 67'sd2147483647;
  localparam logic signed [66:0] WMIN = -67'sd2147483648;

  lav_pkg::back_state_t state, state_next;

  lav_pkg::item_t         it;
  logic                   deg;
  lav_pkg::word_t [2:0]   fwd;
  lav_pkg::word_t [2:0]   fv;
  lav_pkg::word_t [2:0]   rr;
  lav_pkg::word_t [2:0]   trans;
  logic [2:0]             nneg;
  logic [2:0][63:0]       nmag;
  logic [3:0]             cnt;
  logic [1:0]             mrow;
  logic [1:0]             mcomp;
  logic [1:0]             arow;
  logic signed [63:0]     p;
  logic signed [63:0]     pfirst;
  logic signed [65:0]     acc [3];

  lav_pkg::word_t         mul_a;
  lav_pkg::word_t         mul_b;
  logic signed [63:0]     prod;
  logic signed [64:0]     diff;
  logic [1:0]             didx;
  lav_pkg::norm_res_t     nres;
  logic                   nstart;

  function automatic lav_pkg::word_t trans_term(input logic signed [65:0] s);
    logic signed [65:0] rnd;
    logic signed [66:0] nv;
    rnd = (s + HALF) >>> FRAC_BITS;
    nv  = -67'(rnd);
    if (nv > WMAX) return lav_pkg::word_t'(WMAX[31:0]);
    if (nv < WMIN) return lav_pkg::word_t'(WMIN[31:0]);
    return lav_pkg::word_t'(nv[31:0]);
  endfunction

  assign nstart = (state == lav_pkg::B_FSTART) || (state == lav_pkg::B_RSTART);

  lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .neg   (nneg),
    .mag   (nmag),
    .res   (nres)
  );

  // pick multiplier operands
  always_comb begin
    mul_a = it.up[0];
    mul_b = fv[0];
    if (state == lav_pkg::B_CROSS) begin
      unique case (cnt)
        4'd0:    begin mul_a = it.up[1]; mul_b = fv[2]; end
        4'd1:    begin mul_a = it.up[2]; mul_b = fv[1]; end
        4'd2:    begin mul_a = it.up[2]; mul_b = fv[0]; end
        4'd3:    begin mul_a = it.up[0]; mul_b = fv[2]; end
        4'd4:    begin mul_a = it.up[0]; mul_b = fv[1]; end
        default: begin mul_a = it.up[1]; mul_b = fv[0]; end
      endcase
    end else begin
      mul_b = it.cam[mcomp];
      unique case (mrow)
        2'd0:    mul_a = rr[mcomp];
        2'd1:    mul_a = it.up[mcomp];
        default: mul_a = fv[mcomp];
      endcase
    end
  end

  assign prod = 64'(mul_a) * 64'(mul_b);
  assign diff = 65'(pfirst) - 65'(p);
  assign didx = cnt[2:1] - 2'd1;

  assign item_ready = (state == lav_pkg::B_IDLE);
  assign mat_valid  = (state == lav_pkg::B_HAND);
  assign mat.r      = rr;
  assign mat.u      = it.up;
  assign mat.f      = fv;
  assign mat.t      = trans;
  assign mat.deg    = deg;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lav_pkg::B_IDLE: begin
        if (item_valid) begin
          state_next = (item.op == lav_pkg::OP_TARGET) ? lav_pkg::B_FSTART : lav_pkg::B_NEGF;
        end
      end
      lav_pkg::B_FSTART: state_next = lav_pkg::B_FWAIT;
      lav_pkg::B_FWAIT:  if (nres.done) state_next = lav_pkg::B_NEGF;
      lav_pkg::B_NEGF:   state_next = lav_pkg::B_CROSS;
      lav_pkg::B_CROSS:  if (cnt == 4'd6) state_next = lav_pkg::B_RSTART;
      lav_pkg::B_RSTART: state_next = lav_pkg::B_RWAIT;
      lav_pkg::B_RWAIT:  if (nres.done) state_next = lav_pkg::B_DOT;
      lav_pkg::B_DOT:    if (cnt == 4'd9) state_next = lav_pkg::B_TRANS;
      lav_pkg::B_TRANS:  state_next = lav_pkg::B_HAND;
      lav_pkg::B_HAND:   if (mat_ready) state_next = lav_pkg::B_IDLE;
      default:           state_next = lav_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lav_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      lav_pkg::B_IDLE: begin
        if (item_valid) begin
          it  <= item;
          deg <= 1'b0;
          fwd <= item.aim;
          // target minus camera as sign and magnitude
          for (int i = 0; i < 3; i++) begin
            nneg[i] <= (33'(item.aim[i]) - 33'(item.cam[i])) < 0;
            nmag[i] <= ((33'(item.aim[i]) - 33'(item.cam[i])) < 0) ?
                       64'(33'(item.cam[i]) - 33'(item.aim[i])) :
                       64'(33'(item.aim[i]) - 33'(item.cam[i]));
          end
        end
      end
      lav_pkg::B_FWAIT: begin
        if (nres.done) begin
          fwd <= nres.v;
          deg <= nres.zero;
        end
      end
      lav_pkg::B_NEGF: begin
        // negate forward, saturating the most negative word
        for (int i = 0; i < 3; i++) begin
          fv[i] <= (fwd[i] == lav_pkg::word_t'(WMIN[31:0])) ?
                   lav_pkg::word_t'(WMAX[31:0]) : -fwd[i];
        end
        cnt <= 4'd0;
      end
      lav_pkg::B_CROSS: begin
        // products in pairs; each difference is taken from the registered products
        if (cnt < 4'd6) p <= prod;
        if (cnt[0]) pfirst <= p;
        if (!cnt[0] && cnt != 4'd0) begin
          nneg[didx] <= diff[64];
          nmag[didx] <= diff[64] ? 64'(-diff) : 64'(diff);
        end
        cnt <= cnt + 4'd1;
      end
      lav_pkg::B_RWAIT: begin
        if (nres.done) begin
          rr    <= nres.v;
          deg   <= deg | nres.zero;
          cnt   <= 4'd0;
          mrow  <= 2'd0;
          mcomp <= 2'd0;
          for (int i = 0; i < 3; i++) acc[i] <= '0;
        end
      end
      lav_pkg::B_DOT: begin
        // multiply one term, accumulate the previous one
        if (cnt < 4'd9) begin
          p    <= prod;
          arow <= mrow;
          if (mcomp == 2'd2) begin
            mcomp <= 2'd0;
            mrow  <= mrow + 2'd1;
          end else begin
            mcomp <= mcomp + 2'd1;
          end
        end
        if (cnt != 4'd0) acc[arow] <= acc[arow] + 66'(p);
        cnt <= cnt + 4'd1;
      end
      lav_pkg::B_TRANS: begin
        for (int i = 0; i < 3; i++) trans[i] <= trans_term(acc[i]);
      end
      default: ;
    endcase
  end

endmodule

### rtl/lav_emit.sv
// ---------------------------------------------------------------------------
// lav_emit
// Output side: holds one finished matrix and sends it as four row beats.
// ---------------------------------------------------------------------------
module lav_emit #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lav_pkg::matrix_t               mat,
  input  logic                           mat_valid,
  output logic                           mat_ready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lav_pkg::OUT_DATA_W-1:0] m_tdata,  // entry_0, entry_1, entry_2, entry_3
  output logic [lav_pkg::OUT_USER_W-1:0] m_tuser,  // row_index[1:0], degenerate
  output logic                           m_tlast
);

  lav_pkg::matrix_t hold;
  logic             busy;
  logic [1:0]       row;
  lav_pkg::word_t   e0, e1, e2, e3;

  assign mat_ready = !busy;
  assign m_tvalid  = busy;
  assign m_tlast   = (row == 2'd3);
  assign m_tuser   = {hold.deg, row};
  assign m_tdata   = {e3, e2, e1, e0};

  // select the row
  always_comb begin
    unique case (row)
      2'd0: begin e0 = hold.r[0]; e1 = hold.r[1]; e2 = hold.r[2]; e3 = hold.t[0]; end
      2'd1: begin e0 = hold.u[0]; e1 = hold.u[1]; e2 = hold.u[2]; e3 = hold.t[1]; end
      2'd2: begin e0 = hold.f[0]; e1 = hold.f[1]; e2 = hold.f[2]; e3 = hold.t[2]; end
      default: begin
        e0 = '0;
        e1 = '0;
        e2 = '0;
        e3 = lav_pkg::word_t'(1) <<< FRAC_BITS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mat_valid && !busy) hold <= mat;
  end

  // advance through the rows
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= 2'd0;
    end else if (!busy) begin
      if (mat_valid) begin
        busy <= 1'b1;
        row  <= 2'd0;
      end
    end else if (m_tready) begin
      row <= row + 2'd1;
      if (row == 2'd3) busy <= 1'b0;
    end
  end

endmodule

### rtl/look_at_view_matrix.sv
// ---------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix in signed fixed point.
// ---------------------------------------------------------------------------
// Input stream (s_*): one beat per camera: tdata holds camera, aim and up
// vectors; tuser is op (0 aim is the forward direction, 1 aim is a target).
// Output stream (m_*): four beats per camera, rows 0 to 3 of the matrix;
// tuser holds the row index and the degenerate flag, tlast marks row 3.
// A two-entry input queue feeds the compute sequencer; a finished matrix
// waits in the output stage while the next camera is already computed.
// A forward direction needs one normalization and a target point two.
// Each normalization runs 32 square-root steps and 3 x (FRAC_BITS+1)
// divide steps in the shared normalize unit; the cross and dot products
// run on the shared multiplier. The sequencer takes the next camera only
// once the current matrix has gone to the output stage. Rows leave at one
// per cycle while m_tready is high.
// Reset clears the queue, the sequencer and the output stage; a stalled
// receiver holds the current row, and input is taken until the queue fills.
// ---------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lav_pkg::IN_DATA_W-1:0]  s_tdata,  // camera_x/y/z, aim_x/y/z, up_x/y/z
  input  logic                           s_tuser,  // op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lav_pkg::OUT_DATA_W-1:0] m_tdata,  // entry_0, entry_1, entry_2, entry_3
  output logic [lav_pkg::OUT_USER_W-1:0] m_tuser,  // row_index[1:0], degenerate
  output logic                           m_tlast
);

  lav_pkg::item_t   item;
  logic             item_valid;
  logic             item_ready;
  lav_pkg::matrix_t mat;
  logic             mat_valid;
  logic             mat_ready;

  lav_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  lav_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .mat        (mat),
    .mat_valid  (mat_valid),
    .mat_ready  (mat_ready)
  );

  lav_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
    .clk       (clk),
    .rst       (rst),
    .mat       (mat),
    .mat_valid (mat_valid),
    .mat_ready (mat_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

### tb/lav_view_checker.sv
// ---------------------------------------------------------------------------
// lav_view_checker
// Watches both streams of the look-at block. Every camera beat taken on the
// input side is turned into four expected matrix rows. Every row beat on the
// output side is compared field by field with the oldest of those rows.
// ---------------------------------------------------------------------------
module lav_view_checker #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [lav_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [lav_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [lav_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                           m_tlast,
  output int                             error_count,
  output int                             rows_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] BOTTOM_ROW = 2'd3;

  typedef struct {
    logic [1:0]     row;
    lav_pkg::word_t e [4];
    logic           deg;
    logic           last;
  } view_row_t;

  view_row_t expected_rows[$];
  int        rows_seen;

  assign rows_pending = expected_rows.size();

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scale to [2^30, 2^31), take the root of the square sum, divide with
  // half-up rounding. Returns 1 on a zero vector.
  function automatic logic unit_vector(input logic neg [3], input logic [63:0] mag_in [3],
                                       output lav_pkg::word_t v [3]);
    logic [63:0] mag [3];
    logic [63:0] m, sum, n, q;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag_in[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) v[i] = '0;
      return 1'b1;
    end
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    n   = isqrt64(sum);
    for (int i = 0; i < 3; i++) begin
      q    = ((mag[i] << (FRAC_BITS + 1)) + n) / (2 * n);
      v[i] = neg[i] ? -q[31:0] : q[31:0];
    end
    return 1'b0;
  endfunction

  function automatic lav_pkg::word_t sat_word(logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'h7fff_ffff;
    if (x < -128'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // Translation column: -(a.b) rounded half up to FRAC_BITS, saturated.
  function automatic lav_pkg::word_t translation(lav_pkg::word_t a [3], lav_pkg::word_t b [3]);
    logic signed [127:0] acc, x, y;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      x   = a[i];
      y   = b[i];
      acc = acc + x * y;
    end
    acc = (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat_word(-acc);
  endfunction

  task automatic predict_view_rows(logic [lav_pkg::IN_DATA_W-1:0] data, logic op);
    lav_pkg::word_t      cam [3], aim [3], up [3], fwd [3], f [3], r [3];
    logic                neg [3];
    logic [63:0]         mag [3];
    logic signed [127:0] a, b, c, d, diff;
    logic                deg;
    view_row_t           row;
    for (int i = 0; i < 3; i++) begin
      cam[i] = data[i*lav_pkg::WORD_W +: lav_pkg::WORD_W];
      aim[i] = data[(3+i)*lav_pkg::WORD_W +: lav_pkg::WORD_W];
      up[i]  = data[(6+i)*lav_pkg::WORD_W +: lav_pkg::WORD_W];
    end
    deg = 1'b0;
    // forward direction: as given, or normalized target minus camera
    if (op == lav_pkg::OP_TARGET) begin
      for (int i = 0; i < 3; i++) begin
        a      = aim[i];
        b      = cam[i];
        diff   = a - b;
        neg[i] = diff < 0;
        mag[i] = neg[i] ? 64'(-diff) : 64'(diff);
      end
      if (unit_vector(neg, mag, fwd)) deg = 1'b1;
    end else begin
      fwd = aim;
    end
    for (int i = 0; i < 3; i++) begin
      a    = fwd[i];
      f[i] = sat_word(-a);
    end
    // exact cross product up x f
    for (int i = 0; i < 3; i++) begin
      a      = up[(i+1)%3];
      b      = f[(i+2)%3];
      c      = up[(i+2)%3];
      d      = f[(i+1)%3];
      diff   = a * b - c * d;
      neg[i] = diff < 0;
      mag[i] = neg[i] ? 64'(-diff) : 64'(diff);
    end
    if (unit_vector(neg, mag, r)) deg = 1'b1;

    for (int k = 0; k < 3; k++) begin
      row.row  = 2'(k);
      row.deg  = deg;
      row.last = 1'b0;
      for (int i = 0; i < 3; i++) row.e[i] = (k == 0) ? r[i] : (k == 1) ? up[i] : f[i];
      row.e[3] = (k == 0) ? translation(r, cam) :
                 (k == 1) ? translation(up, cam) : translation(f, cam);
      expected_rows.push_back(row);
    end
    row.row  = BOTTOM_ROW;
    row.e[0] = '0;
    row.e[1] = '0;
    row.e[2] = '0;
    row.e[3] = 32'sd1 <<< FRAC_BITS;
    row.last = 1'b1;
    expected_rows.push_back(row);
  endtask

  task automatic report_mismatch(string what, int row_no, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH row beat %0d: %s got %h expected %h", row_no, what, got, want);
    error_count++;
  endtask

  initial error_count = 0;
  initial rows_seen = 0;

  always @(posedge clk) begin
    view_row_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_view_rows(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (expected_rows.size() == 0) begin
          $display("UNEXPECTED row beat %0d: no row pending", rows_seen);
          error_count++;
        end else begin
          want = expected_rows.pop_front();
          if (m_tuser[1:0] != want.row)
            report_mismatch("row_index", rows_seen, m_tuser[1:0], want.row);
          for (int i = 0; i < 4; i++)
            if (m_tdata[i*lav_pkg::WORD_W +: lav_pkg::WORD_W] != want.e[i])
              report_mismatch($sformatf("entry_%0d", i), rows_seen,
                              m_tdata[i*lav_pkg::WORD_W +: lav_pkg::WORD_W], want.e[i]);
          if (m_tuser[2] != want.deg)
            report_mismatch("degenerate", rows_seen, m_tuser[2], want.deg);
          if (m_tlast != want.last) report_mismatch("last", rows_seen, m_tlast, want.last);
        end
        rows_seen++;
      end
    end
  end

endmodule

### tb/tb_look_at_view_matrix.sv
// ---------------------------------------------------------------------------
// tb_look_at_view_matrix
// Drives camera beats into the look-at block: a directed set of edge cases,
// then a random mix of plausible scenes and raw bit patterns, with random
// gaps and back-pressure. The checker beside the block judges every row.
// ---------------------------------------------------------------------------
module tb_look_at_view_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CAMERAS = 380;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int LONG_HOLD      = 800;
  localparam int ONE            = 1 << lav_pkg::FRAC_BITS_DEF;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [lav_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           s_tuser = lav_pkg::OP_FORWARD;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [lav_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [lav_pkg::OUT_USER_W-1:0] m_tuser;
  logic                           m_tlast;
  int                             error_count;
  int                             rows_pending;
  int                             cycle_count = 0;
  logic                           hold_off_req = 1'b0;
  logic                           gaps_on = 1'b1;

  always #5 clk = ~clk;

  look_at_view_matrix dut (.*);

  lav_view_checker checker_i (.*);

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, stall-free stretches, one long hold-off on request
  initial begin
    int stall;
    int hold;
    bit hold_used;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_used) begin
        hold      = LONG_HOLD;
        hold_used = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0)
          stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
    end
  end

  function automatic lav_pkg::word_t rand_word();
    return lav_pkg::word_t'($urandom);
  endfunction

  function automatic lav_pkg::word_t rand_range(int span);
    return lav_pkg::word_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // offer one camera beat, hold it until taken, then maybe idle
  task automatic send_camera(logic op, lav_pkg::word_t cam [3], lav_pkg::word_t aim [3],
                             lav_pkg::word_t up [3]);
    int gap;
    logic [lav_pkg::IN_DATA_W-1:0] data;
    for (int i = 0; i < 3; i++) begin
      data[i*lav_pkg::WORD_W +: lav_pkg::WORD_W]     = cam[i];
      data[(3+i)*lav_pkg::WORD_W +: lav_pkg::WORD_W] = aim[i];
      data[(6+i)*lav_pkg::WORD_W +: lav_pkg::WORD_W] = up[i];
    end
    s_tdata  <= data;
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = 0;
    if (gaps_on && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 80);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
  endtask

  initial begin
    lav_pkg::word_t cam [3], aim [3], up [3];
    lav_pkg::word_t wmax, wmin;
    wmax = 32'h7fff_ffff;
    wmin = 32'h8000_0000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain view along -z with y up
    cam = '{0, 0, 5 * ONE};  aim = '{0, 0, -ONE};  up = '{0, ONE, 0};
    send_camera(lav_pkg::OP_FORWARD, cam, aim, up);
    aim = '{ONE, 2 * ONE, 0};
    send_camera(lav_pkg::OP_TARGET, cam, aim, up);
    // target equals camera: zero forward
    aim = cam;
    send_camera(lav_pkg::OP_TARGET, cam, aim, up);
    // forward parallel to up: zero cross product
    aim = '{0, 3 * ONE, 0};
    send_camera(lav_pkg::OP_FORWARD, cam, aim, up);
    aim = '{0, 0, 0};
    send_camera(lav_pkg::OP_FORWARD, cam, aim, up);
    // most negative forward saturates on negation
    aim = '{wmin, wmin, 0};
    send_camera(lav_pkg::OP_FORWARD, cam, aim, up);
    aim = '{wmin, wmin, wmin};  up = '{wmax, wmin, ONE};
    send_camera(lav_pkg::OP_FORWARD, cam, aim, up);
    // translation saturates both ways
    cam = '{wmax, wmax, wmax};  aim = '{wmax, wmin, wmax};  up = '{wmax, wmax, wmax};
    send_camera(lav_pkg::OP_FORWARD, cam, aim, up);
    cam = '{wmin, wmin, wmin};
    send_camera(lav_pkg::OP_FORWARD, cam, aim, up);
    // widest target differences
    cam = '{wmin, wmax, wmin};  aim = '{wmax, wmin, wmax};  up = '{0, ONE, 0};
    send_camera(lav_pkg::OP_TARGET, cam, aim, up);
    cam = '{wmax, wmin, 0};  aim = '{wmin, wmax, 0};
    send_camera(lav_pkg::OP_TARGET, cam, aim, up);
    // tiny target difference scales up
    cam = '{ONE, ONE, ONE};  aim = '{ONE + 1, ONE, ONE - 1};
    send_camera(lav_pkg::OP_TARGET, cam, aim, up);
    cam = '{-1, -1, -1};  aim = '{1, 1, 1};  up = '{-1, 0, 1};
    send_camera(lav_pkg::OP_TARGET, cam, aim, up);
    // all zeros, all ones
    cam = '{0, 0, 0};  aim = '{0, 0, 0};  up = '{0, 0, 0};
    send_camera(lav_pkg::OP_TARGET, cam, aim, up);
    cam = '{-1, -1, -1};  aim = '{-1, -1, -1};  up = '{-1, -1, -1};
    send_camera(lav_pkg::OP_FORWARD, cam, aim, up);
    cam = '{wmax, wmax, wmax};  aim = '{wmin, wmin, wmin};  up = '{wmin, 0, wmax};
    send_camera(lav_pkg::OP_TARGET, cam, aim, up);

    // pause until every row is out
    wait_drained();

    for (int n = 0; n < RANDOM_CAMERAS; n++) begin
      // alternate stretches with and without idling
      if (n % 60 == 0) gaps_on = (n % 120 == 0) ? 1'b1 : 1'b0;
      // long receiver hold-off while the sender keeps going
      hold_off_req = (n >= 100 && n < 104);
      if ($urandom_range(0, 9) < 7) begin
        // plausible scene: small coordinates, unit-ish up
        for (int i = 0; i < 3; i++) begin
          cam[i] = rand_range(200 * ONE);
          aim[i] = rand_range(200 * ONE);
        end
        case ($urandom_range(0, 3))
          0: up = '{0, ONE, 0};
          1: up = '{0, 0, ONE};
          2: up = '{ONE, 0, 0};
          default: for (int i = 0; i < 3; i++) up[i] = rand_range(ONE);
        endcase
        if ($urandom_range(0, 19) == 0) aim = cam;
      end else begin
        for (int i = 0; i < 3; i++) begin
          cam[i] = rand_word();
          aim[i] = rand_word();
          up[i]  = rand_word();
        end
      end
      send_camera($urandom_range(0, 1) ? lav_pkg::OP_TARGET : lav_pkg::OP_FORWARD,
                  cam, aim, up);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lav_pkg.sv
rtl/lav_front.sv
rtl/lav_norm.sv
rtl/lav_back.sv
rtl/lav_emit.sv
rtl/look_at_view_matrix.sv
tb/lav_view_checker.sv
tb/tb_look_at_view_matrix.sv
